>>> hw/rtl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

  // Message word as it arrives
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_item_t;

  // Digest as it leaves
  typedef struct packed {
    logic [63:0] digest_words_0_1;
    logic [63:0] digest_words_2_3;
    logic [63:0] digest_words_4_5;
    logic [63:0] digest_words_6_7;
  } out_item_t;

  // One padded 64-byte block on its way from the front to the round engine
  typedef struct packed {
    logic [511:0] data;
    logic         final_blk;
    logic         dbl;
  } blk_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] DBL_BITS = 32'd256;
  localparam logic [2:0]  WORD_BYTES = 3'd4;
  localparam logic [5:0]  LEN_POS = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hw/rtl/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
// SHA-256 / SHA-256d stream hasher.
// Input channel (in_valid/in_ready/in_data): one big-endian message word per
// item with 0..4 left-aligned valid bytes (more count as 4); last marks the end of a message.
// Output channel (out_valid/out_ready/out_data): one 256-bit digest per
// message, h0 in the top half of digest_words_0_1.
// cfg_we/cfg_wdata write the double-hash mode bit; write it between messages.
// Flow: the front takes a word only when idle, then packs its bytes one a cycle
// (it holds the last byte of a block while the queue is full); the round engine
// runs each 64-byte block through a fetch, 64 rounds and one fold, so for full
// words the front sets the sustained rate.
// A two-entry block queue lets the front keep taking words while the engine
// works. After the last word come its bytes, a padding step, then one or two
// compressions (plus one more in double-hash mode), and the digest is then
// registered in the output register.
// Reset clears the chaining value to the initial hash, empties the queue and
// drops any result. A stalled receiver holds the digest in the output
// register; the engine then waits, the queue fills, and in_ready drops.
module sha256_stream_hasher_core #(
  parameter int QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  logic             dbl_r, dbl_nxt;
  logic             blk_push, blk_ready, blk_pop, head_valid;
  sha256_pkg::blk_t push_data, head_data;

  // Hold the mode bit
  assign dbl_nxt = cfg_we ? cfg_wdata : dbl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r <= 1'b0;
    end else begin
      dbl_r <= dbl_nxt;
    end
  end

  sha256_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .dbl_mode  (dbl_r),
    .blk_push  (blk_push),
    .blk_data  (push_data),
    .blk_ready (blk_ready)
  );

  sha256_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (blk_push),
    .push_data  (push_data),
    .push_ready (blk_ready),
    .pop        (blk_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  sha256_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (head_valid),
    .blk_data  (head_data),
    .blk_pop   (blk_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/sha256_front.sv
`timescale 1ns / 1ps
module sha256_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha256_pkg::in_item_t in_data,
  input  logic                 dbl_mode,
  output logic                 blk_push,
  output sha256_pkg::blk_t     blk_data,
  input  logic                 blk_ready
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_BYTES = 4'b0010,
    F_PAD   = 4'b0100,
    F_LEN   = 4'b1000
  } fst_t;

  fst_t          st_r, st_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [2:0]    nb_r, nb_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    bi_r, bi_nxt;
  logic [511:0]  buf_r, buf_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [63:0]   len_r, len_nxt;
  logic [7:0]    cur_byte;
  logic [511:0]  buf_wr;
  logic [2:0]    nb_in;

  // Clamp the byte count to one word
  assign nb_in = (in_data.valid_bytes > sha256_pkg::WORD_BYTES) ?
                 sha256_pkg::WORD_BYTES : in_data.valid_bytes;
  assign in_ready = (st_r == F_IDLE);

  // Byte to place and the buffer with it written at the fill position
  always_comb begin
    cur_byte = (st_r == F_PAD) ? sha256_pkg::PAD_BYTE : word_r[5'd31 - {bi_r, 3'b000} -: 8];
    buf_wr = buf_r;
    buf_wr[9'd511 - {fill_r, 3'b000} -: 8] = cur_byte;
  end

  always_comb begin
    st_nxt   = st_r;
    word_nxt = word_r;
    nb_nxt   = nb_r;
    last_nxt = last_r;
    bi_nxt   = bi_r;
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    len_nxt  = len_r;
    blk_push = 1'b0;
    blk_data.data      = buf_wr;
    blk_data.final_blk = 1'b0;
    blk_data.dbl       = dbl_mode;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          word_nxt = in_data.message_word;
          nb_nxt   = nb_in;
          last_nxt = in_data.last;
          bi_nxt   = '0;
          if (nb_in != 3'd0) begin
            st_nxt = F_BYTES;
          end else if (in_data.last) begin
            st_nxt = F_PAD;
          end
        end
      end
      // Pack one byte a cycle unless a full block waits for queue space; hand off a full block
      F_BYTES: begin
        if (fill_r != 6'd63 || blk_ready) begin
          len_nxt = len_r + 64'd8;
          if (fill_r == 6'd63) begin
            blk_push = 1'b1;
            buf_nxt  = '0;
            fill_nxt = '0;
          end else begin
            buf_nxt  = buf_wr;
            fill_nxt = fill_r + 6'd1;
          end
          if ({1'b0, bi_r} + 3'd1 == nb_r) begin
            st_nxt = last_r ? F_PAD : F_IDLE;
          end else begin
            bi_nxt = bi_r + 2'd1;
          end
        end
      end
      // Append the pad byte, and the length if it still fits
      F_PAD: begin
        if (blk_ready) begin
          blk_push = 1'b1;
          if (fill_r < sha256_pkg::LEN_POS) begin
            blk_data.data      = {buf_wr[511:64], len_r};
            blk_data.final_blk = 1'b1;
            len_nxt = '0;
            st_nxt  = F_IDLE;
          end else begin
            st_nxt = F_LEN;
          end
          buf_nxt  = '0;
          fill_nxt = '0;
        end
      end
      F_LEN: begin
        blk_data.data      = {448'd0, len_r};
        blk_data.final_blk = 1'b1;
        if (blk_ready) begin
          blk_push = 1'b1;
          len_nxt  = '0;
          st_nxt   = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      fill_r <= '0;
      len_r  <= '0;
      buf_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      buf_r  <= buf_nxt;
    end
    word_r <= word_nxt;
    nb_r   <= nb_nxt;
    last_r <= last_nxt;
    bi_r   <= bi_nxt;
  end

endmodule

>>> hw/rtl/sha256_queue.sv
`timescale 1ns / 1ps
module sha256_queue #(
  parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sha256_pkg::blk_t push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output sha256_pkg::blk_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha256_pkg::blk_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !push_ready)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid)) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

>>> hw/rtl/sha256_back.sv
`timescale 1ns / 1ps
module sha256_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  blk_valid,
  input  sha256_pkg::blk_t      blk_data,
  output logic                  blk_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_DONE  = 4'b1000
  } bst_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  bst_t        st_r, st_nxt;
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [5:0]  rnd_r, rnd_nxt;
  logic        final_r, final_nxt;
  logic        dbl_r, dbl_nxt;
  logic        second_r, second_nxt;
  logic        out_valid_r, out_valid_nxt;
  sha256_pkg::out_item_t out_data_r, out_data_nxt;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, w_new, s0, s1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One compression round and the next schedule word
  always_comb begin
    big_s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    big_s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1     = v_r[7] + big_s1 + ch + sha256_pkg::ROUND_K[rnd_r] + w_r[0];
    t2     = big_s0 + maj;
    s0     = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1     = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new  = s1 + w_r[9] + s0 + w_r[0];
  end

  always_comb begin
    st_nxt        = st_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    rnd_nxt       = rnd_r;
    final_nxt     = final_r;
    dbl_nxt       = dbl_r;
    second_nxt    = second_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    blk_pop       = 1'b0;
    unique case (st_r)
      // Take the next block and seed the working variables
      B_IDLE: begin
        if (blk_valid) begin
          blk_pop   = 1'b1;
          for (int i = 0; i < 16; i++) begin
            w_nxt[i] = blk_data.data[511 - 32*i -: 32];
          end
          v_nxt     = h_r;
          rnd_nxt   = '0;
          final_nxt = blk_data.final_blk;
          dbl_nxt   = blk_data.dbl;
          st_nxt    = B_ROUND;
        end
      end
      B_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          st_nxt = B_ADD;
        end
      end
      // Fold the working variables into the chaining value
      B_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        st_nxt = final_r ? B_DONE : B_IDLE;
      end
      // Rehash the digest once in double-hash mode, or hold it until the output slot frees and emit it
      B_DONE: begin
        if (dbl_r && !second_r) begin
          for (int i = 0; i < 8; i++) begin
            w_nxt[i] = h_r[i];
          end
          w_nxt[8] = sha256_pkg::PAD_WORD;
          for (int i = 9; i < 15; i++) begin
            w_nxt[i] = '0;
          end
          w_nxt[15]  = sha256_pkg::DBL_BITS;
          h_nxt      = sha256_pkg::IV;
          v_nxt      = sha256_pkg::IV;
          rnd_nxt    = '0;
          second_nxt = 1'b1;
          st_nxt     = B_ROUND;
        end else if (!out_valid_r || out_ready) begin
          out_data_nxt.digest_words_0_1 = {h_r[0], h_r[1]};
          out_data_nxt.digest_words_2_3 = {h_r[2], h_r[3]};
          out_data_nxt.digest_words_4_5 = {h_r[4], h_r[5]};
          out_data_nxt.digest_words_6_7 = {h_r[6], h_r[7]};
          out_valid_nxt = 1'b1;
          h_nxt         = sha256_pkg::IV;
          second_nxt    = 1'b0;
          st_nxt        = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      h_r         <= sha256_pkg::IV;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      h_r         <= h_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    rnd_r      <= rnd_nxt;
    final_r    <= final_nxt;
    dbl_r      <= dbl_nxt;
    out_data_r <= out_data_nxt;
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == B_DONE)) else $error("digest not from done");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_ROUND && rnd_r == 6'd63) |=> st_r == B_ADD) else $error("round count slip");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    blk_pop |-> (st_r == B_IDLE && blk_valid)) else $error("pop outside idle");

endmodule

>>> test/sha256_checker.sv
`timescale 1ns / 1ps
module sha256_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sha256_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sha256_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  output int                    fail_count,
  output int                    digests_pending
);

  logic [31:0] chain[8];
  logic [31:0] blk_words[16];
  logic [31:0] sched[16];
  int unsigned byte_fill;
  logic [63:0] msg_bits;
  logic        dbl_mode;
  sha256_pkg::out_item_t digest_q[$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over blk_words and fold into the chaining value
  function automatic void compress();
    logic [31:0] v[8];
    logic [31:0] wt, x15, x2, e, a, t1, t2;
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = blk_words[t];
      end else begin
        x15 = sched[(t - 15) & 15];
        x2 = sched[(t - 2) & 15];
        wt = sched[(t - 16) & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
           + sched[(t - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
      end
      sched[t & 15] = wt;
      e = v[4];
      a = v[0];
      t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + sha256_pkg::ROUND_K[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
  endfunction

  function automatic void add_byte(logic [7:0] b);
    int unsigned idx;
    idx = byte_fill >> 2;
    if ((byte_fill & 3) == 0) blk_words[idx] = '0;
    blk_words[idx] = blk_words[idx] | (32'(b) << (24 - 8 * (byte_fill & 3)));
    byte_fill++;
    if (byte_fill >= 64) begin
      compress();
      byte_fill = 0;
    end
  endfunction

  function automatic void reset_chain();
    for (int j = 0; j < 8; j++) chain[j] = sha256_pkg::IV[j];
  endfunction

  // Absorb one word; on the last word pad, optionally rehash, queue the digest
  function automatic void absorb_word(sha256_pkg::in_item_t it);
    int unsigned nb;
    logic [63:0] len;
    sha256_pkg::out_item_t d;
    nb = (it.valid_bytes > sha256_pkg::WORD_BYTES) ? sha256_pkg::WORD_BYTES : it.valid_bytes;
    for (int i = 0; i < nb; i++) begin
      add_byte(it.message_word[31 - 8 * i -: 8]);
      msg_bits = msg_bits + 64'd8;
    end
    if (!it.last) return;
    len = msg_bits;
    add_byte(sha256_pkg::PAD_BYTE);
    while (byte_fill != sha256_pkg::LEN_POS) add_byte(8'h00);
    blk_words[14] = len[63:32];
    blk_words[15] = len[31:0];
    compress();
    byte_fill = 0;
    if (dbl_mode) begin
      for (int i = 0; i < 8; i++) blk_words[i] = chain[i];
      blk_words[8] = sha256_pkg::PAD_WORD;
      for (int i = 9; i < 15; i++) blk_words[i] = '0;
      blk_words[15] = sha256_pkg::DBL_BITS;
      reset_chain();
      compress();
    end
    d.digest_words_0_1 = {chain[0], chain[1]};
    d.digest_words_2_3 = {chain[2], chain[3]};
    d.digest_words_4_5 = {chain[4], chain[5]};
    d.digest_words_6_7 = {chain[6], chain[7]};
    digest_q.push_back(d);
    reset_chain();
    byte_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void cmp_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %h actual %h", $realtime, nm, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Track config, predict on each accepted word, check each accepted digest
  always @(posedge clk) begin
    sha256_pkg::out_item_t e;
    if (!rst_n) begin
      reset_chain();
      byte_fill = 0;
      msg_bits = '0;
      dbl_mode = 1'b0;
      fail_count = 0;
      digest_q.delete();
    end else begin
      if (cfg_we) dbl_mode = cfg_wdata;
      if (in_valid && in_ready) absorb_word(in_data);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest expected none actual %h", $realtime, out_data);
          fail_count++;
        end else begin
          e = digest_q.pop_front();
          cmp_field("digest_words_0_1", e.digest_words_0_1, out_data.digest_words_0_1);
          cmp_field("digest_words_2_3", e.digest_words_2_3, out_data.digest_words_2_3);
          cmp_field("digest_words_4_5", e.digest_words_4_5, out_data.digest_words_4_5);
          cmp_field("digest_words_6_7", e.digest_words_6_7, out_data.digest_words_6_7);
        end
      end
    end
    digests_pending = digest_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_WORDS = 1050;
  localparam int DRAIN_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sha256_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sha256_pkg::out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;
  int        fail_count;
  int        digests_pending;
  int        cycles;
  int        words_sent;

  sha256_stream_hasher_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  sha256_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .digests_pending(digests_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on runaway
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Receiver backpressure
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until taken, then maybe idle
  task automatic send_word(logic [31:0] w, logic [2:0] nb, logic lst);
    int g;
    in_valid <= 1'b1;
    in_data <= '{message_word: w, valid_bytes: nb, last: lst};
    do @(posedge clk); while (!in_ready);
    words_sent++;
    g = (words_sent % 97 < 20) ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Message of nbytes random bytes, full words (if noisy, now and then a word of 0..7 bytes) then a 1..4 byte tail
  task automatic send_msg(int nbytes, bit noisy);
    int left;
    int nb;
    left = nbytes;
    while (left > 4) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        nb = $urandom_range(0, 7);
        send_word($urandom(), 3'(nb), 1'b0);
        left -= (nb > 4) ? 4 : nb;
      end else begin
        send_word($urandom(), sha256_pkg::WORD_BYTES, 1'b0);
        left -= 4;
      end
    end
    if (left <= 0) left = 1;
    send_word($urandom(), 3'(left), 1'b1);
  endtask

  // Let the engine go idle, then switch the mode bit
  task automatic set_mode(logic m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int len;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b0);

    // Directed: empty message, extremes, padding boundaries, odd byte counts
    for (int m = 0; m < 2; m++) begin
      send_word(32'h0000_0000, 3'd0, 1'b1);
      send_word(32'h6162_6300, 3'd3, 1'b1);
      send_word(32'hffff_ffff, 3'd7, 1'b1);
      send_word(32'h0000_0000, 3'd5, 1'b0);
      send_word(32'hffff_ffff, 3'd1, 1'b0);
      send_word(32'h0000_0000, 3'd6, 1'b1);
      send_msg(55, 1'b0);
      send_msg(56, 1'b0);
      send_msg(64, 1'b0);
      set_mode(1'b1);
    end
    set_mode(1'b0);

    // Random messages, mode flipped between phases
    for (int ph = 0; words_sent < RAND_WORDS - 60; ph++) begin
      for (int k = 0; k < 12; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_word($urandom(), 3'd0, 1'b1);
        end else begin
          if (r < 70) len = $urandom_range(1, 70);
          else if (r < 90) len = 55 + 64 * $urandom_range(0, 1) + $urandom_range(0, 10);
          else len = $urandom_range(71, 200);
          send_msg(len, $urandom_range(0, 4) == 0);
        end
      end
      set_mode(ph[0]);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_front.sv
hw/rtl/sha256_queue.sv
hw/rtl/sha256_back.sv
hw/rtl/sha256_stream_hasher_core.sv
test/sha256_checker.sv
test/tb_top.sv
